// ----- hw/rtl/unsigned_to_decimal_ascii_defines.svh -----
// Assertion helpers shared by the conversion block.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U2DA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U2DA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/u2da_pkg.sv -----
package u2da_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned BCD_W           = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CHAR_W          = 6;
  localparam int unsigned COUNT_W         = 4;
  localparam int unsigned OUT_TDATA_W     = 16;
  // bits of binary input folded in by one pipeline stage
  localparam int unsigned STEP_BITS       = 8;
  // widths at or above this can exceed ten decimal digits
  localparam int unsigned SAT_W           = 34;
  localparam logic [63:0] SAT_VALUE       = 64'd9999999999;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    bcd_t               bcd;    // leading digit aligned to the top nibble
    logic [COUNT_W-1:0] count;
  } norm_t;

  typedef struct packed {
    logic               holding;
    logic [COUNT_W-1:0] left;
  } ser_status_t;

endpackage

// ----- hw/rtl/u2da_dabble_stage.sv -----
module u2da_dabble_stage #(
  parameter int unsigned BIN_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  u2da_pkg::bcd_t    bcd_i,
  input  logic [BIN_W-1:0]  bin_i,
  output logic              valid_o,
  input  logic              ready_i,
  output u2da_pkg::bcd_t    bcd_o,
  output logic [BIN_W-1:0]  bin_o
);

  logic             valid_q;
  u2da_pkg::bcd_t   bcd_d, bcd_q;
  logic [BIN_W-1:0] bin_d, bin_q;

  assign ready_o = !valid_q || ready_i;

  // Shift-and-add-3 over the top bits of the remaining binary word.
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < u2da_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < u2da_pkg::NUM_DIGITS; d++) begin
        if (bcd_d[d*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] >= 4'd5) begin
          bcd_d[d*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] =
            bcd_d[d*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] + 4'd3;
        end
      end
      {bcd_d, bin_d} = {bcd_d[u2da_pkg::BCD_W-2:0], bin_d, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

// ----- hw/rtl/u2da_normalize.sv -----
module u2da_normalize (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  u2da_pkg::bcd_t    bcd_i,
  output logic              valid_o,
  input  logic              ready_i,
  output u2da_pkg::norm_t   norm_o
);

  logic                           valid_q;
  u2da_pkg::norm_t                norm_d, norm_q;
  logic [u2da_pkg::COUNT_W-1:0]   count;
  logic [5:0]                     shamt;

  assign ready_o = !valid_q || ready_i;

  // Count significant digits (at least one) and move the leading one to the top.
  always_comb begin
    count = 4'd1;
    for (int d = 1; d < u2da_pkg::NUM_DIGITS; d++) begin
      if (bcd_i[d*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] != 4'd0) begin
        count = 4'(d + 1);
      end
    end
    shamt        = {(4'(u2da_pkg::NUM_DIGITS) - count), 2'b00};
    norm_d.bcd   = bcd_i << shamt;
    norm_d.count = count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      norm_q <= norm_d;
    end
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;

endmodule

// ----- hw/rtl/u2da_serializer.sv -----
module u2da_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  u2da_pkg::norm_t               norm_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [u2da_pkg::CHAR_W-1:0]   char_o,
  output logic                          last_o,
  output logic [u2da_pkg::COUNT_W-1:0]  count_o,
  output u2da_pkg::ser_status_t         status_o
);

  logic                          out_valid_q;
  logic [u2da_pkg::COUNT_W-1:0]  left_q;
  logic [u2da_pkg::CHAR_W-1:0]   char_q;
  logic                          last_q;
  logic [u2da_pkg::COUNT_W-1:0]  count_q;
  u2da_pkg::bcd_t                shift_q;
  logic                          out_free;
  logic                          more;

  assign out_free = !out_valid_q || out_ready_i;
  assign more     = (left_q != '0);
  // take a new request only once every digit of the current one is out
  assign ready_o  = out_free && !more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else if (out_free) begin
      if (more) begin
        out_valid_q <= 1'b1;
        left_q      <= left_q - 4'd1;
      end else if (valid_i) begin
        out_valid_q <= 1'b1;
        left_q      <= norm_i.count - 4'd1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (more) begin
        char_q  <= u2da_pkg::ASCII_ZERO +
                   6'(shift_q[u2da_pkg::BCD_W-1 -: u2da_pkg::DIGIT_W]);
        last_q  <= (left_q == 4'd1);
        shift_q <= shift_q << u2da_pkg::DIGIT_W;
      end else if (valid_i) begin
        char_q  <= u2da_pkg::ASCII_ZERO +
                   6'(norm_i.bcd[u2da_pkg::BCD_W-1 -: u2da_pkg::DIGIT_W]);
        last_q  <= (norm_i.count == 4'd1);
        count_q <= norm_i.count;
        shift_q <= norm_i.bcd << u2da_pkg::DIGIT_W;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign char_o           = char_q;
  assign last_o           = last_q;
  assign count_o          = count_q;
  assign status_o.holding = out_valid_q;
  assign status_o.left    = left_q;

endmodule

// ----- hw/rtl/unsigned_to_decimal_ascii.sv -----
// Unsigned binary to decimal ASCII text.
// Slave stream: one request per value; tdata holds the value (zero padded to bytes).
// Master stream: one character per beat, most significant digit first, no
// leading zeros (zero gives a single '0'). tdata carries the ASCII code and the
// value's total digit count; tlast marks the least significant digit.
// Values that need more than ten digits (only with VALUE_WIDTH of 34 or more)
// saturate to 9999999999.
// Pipeline from request to first character: input register, one
// shift-and-add-3 stage per 8 input bits (counting at most 34 bits), a digit
// count stage and the output register.
// Throughput: the one-character-per-cycle output register sets the rate while
// m_axis_tready is high; values follow one another without gaps while later
// ones advance through the pipeline.
// Reset clears every valid bit; no request is lost on reset release.
// When the receiver holds tready low the output beat holds, the pipeline fills
// up and s_axis_tready falls once every stage is occupied.
`include "unsigned_to_decimal_ascii_defines.svh"

module unsigned_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [VALUE_WIDTH-1:0] value, rest zero
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [5:0] digit_char, [9:6] digit_count, [15:10] zero
  output logic [u2da_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast
);

  localparam int unsigned CONV_W =
    (VALUE_WIDTH > u2da_pkg::SAT_W) ? u2da_pkg::SAT_W : VALUE_WIDTH;
  localparam int unsigned NSTG   = (CONV_W + u2da_pkg::STEP_BITS - 1) / u2da_pkg::STEP_BITS;
  localparam int unsigned PAD_W  = NSTG * u2da_pkg::STEP_BITS;

  logic [CONV_W-1:0]            conv;
  logic                         in_valid_q;
  logic [PAD_W-1:0]             in_bin_q;
  logic [NSTG:0]                stg_valid;
  logic [NSTG:0]                stg_ready;
  u2da_pkg::bcd_t               stg_bcd [NSTG+1];
  logic [PAD_W-1:0]             stg_bin [NSTG+1];
  logic                         norm_valid;
  logic                         norm_ready;
  u2da_pkg::norm_t              norm;
  logic [u2da_pkg::CHAR_W-1:0]  out_char;
  logic [u2da_pkg::COUNT_W-1:0] out_count;
  u2da_pkg::ser_status_t        ser_status;

  // Clamp to ten digits where the input width allows more.
  if (VALUE_WIDTH >= u2da_pkg::SAT_W) begin : g_sat
    assign conv = (s_axis_tdata[VALUE_WIDTH-1:0] > VALUE_WIDTH'(u2da_pkg::SAT_VALUE)) ?
                  CONV_W'(u2da_pkg::SAT_VALUE) : s_axis_tdata[CONV_W-1:0];
  end else begin : g_nosat
    assign conv = s_axis_tdata[CONV_W-1:0];
  end

  assign s_axis_tready = !in_valid_q || stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_bin_q <= PAD_W'(conv);
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_bcd[0]   = '0;
  assign stg_bin[0]   = in_bin_q;

  for (genvar g = 0; g < NSTG; g++) begin : g_dabble
    u2da_dabble_stage #(
      .BIN_W (PAD_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .bcd_i   (stg_bcd[g]),
      .bin_i   (stg_bin[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .bcd_o   (stg_bcd[g+1]),
      .bin_o   (stg_bin[g+1])
    );
  end

  u2da_normalize u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[NSTG]),
    .ready_o (stg_ready[NSTG]),
    .bcd_i   (stg_bcd[NSTG]),
    .valid_o (norm_valid),
    .ready_i (norm_ready),
    .norm_o  (norm)
  );

  u2da_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (norm_valid),
    .ready_o     (norm_ready),
    .norm_i      (norm),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .char_o      (out_char),
    .last_o      (m_axis_tlast),
    .count_o     (out_count),
    .status_o    (ser_status)
  );

  assign m_axis_tdata = {6'b000000, out_count, out_char};

  `U2DA_ASSERT_IMP(a_bin_drained, clk_i, rst_ni, stg_valid[NSTG], stg_bin[NSTG] == '0, "binary bits left after last conversion stage")
  `U2DA_ASSERT_IMP(a_pending_holds, clk_i, rst_ni, ser_status.left != '0, ser_status.holding, "digits pending with empty output register")
  `U2DA_ASSERT_IMP(a_last_drained, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, ser_status.left == '0, "last digit shown while digits still pending")
  `U2DA_ASSERT_NXT(a_next_digit, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[9:6] == $past(m_axis_tdata[9:6])), "digit run broken or count changed")

endmodule

// ----- tb/sv/unsigned_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_test;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IN_TDATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int unsigned CHAR_W = u2da_pkg::CHAR_W;
  localparam int unsigned COUNT_W = u2da_pkg::COUNT_W;
  localparam int unsigned NUM_DIGITS = u2da_pkg::NUM_DIGITS;
  localparam int unsigned OUT_TDATA_W = u2da_pkg::OUT_TDATA_W;
  localparam int unsigned DEC_BASE = 10;
  localparam int unsigned RANDOM_VALUES = 155;
  localparam int unsigned QUIET_FROM = 125;
  localparam int unsigned HOLD_AFTER = 30;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] cnt;
  } digit_beat_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;
  } vector_t;

  // empty text: expectation comes from the predictor
  vector_t directed_vecs [25] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd99,         "99"},
    '{32'd100,        "100"},
    '{32'd999,        ""},
    '{32'd1000,       ""},
    '{32'd9999,       ""},
    '{32'd10000,      ""},
    '{32'd99999,      ""},
    '{32'd100000,     ""},
    '{32'd999999,     ""},
    '{32'd1000000,    ""},
    '{32'd9999999,    ""},
    '{32'd10000000,   ""},
    '{32'd99999999,   ""},
    '{32'd100000000,  ""},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'hFFFF_FFFF,  "4294967295"},
    '{32'hFFFF_FFFE,  ""},
    '{32'h8000_0000,  ""},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [31:0] value
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [5:0] digit_char, [9:6] digit_count, [15:10] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  digit_beat_t pending_chars [$];
  int unsigned mismatches = 0;
  int unsigned values_taken = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;

  unsigned_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Decimal digits of v, most significant first, one beat each.
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [3:0]         digs [NUM_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    digit_beat_t        b;
    rest = v;
    n = 0;
    do begin
      digs[n] = 4'(rest % DEC_BASE);
      rest = rest / DEC_BASE;
      n++;
    end while (rest != 0 && n < NUM_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      b.ch = u2da_pkg::ASCII_ZERO + CHAR_W'(digs[k]);
      b.last = (k == 0);
      b.cnt = COUNT_W'(n);
      pending_chars.push_back(b);
    end
  endfunction

  task automatic offer(input logic [VALUE_W-1:0] v, input string text);
    digit_beat_t b;
    byte         c;
    s_axis_tdata <= v;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    values_taken++;
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c = text[i];
        b.ch = c[CHAR_W-1:0];
        b.last = (i == text.len() - 1);
        b.cnt = COUNT_W'(text.len());
        pending_chars.push_back(b);
      end
    end
  endtask

  task automatic pause_sender();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off to back up the pipeline.
  initial begin
    m_axis_tready <= 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && values_taken >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected character: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[CHAR_W-1:0] != want.ch || m_axis_tlast != want.last ||
            m_axis_tdata[CHAR_W +: COUNT_W] != want.cnt) begin
          if (mismatches < MAX_REPORTS)
            $display("char mismatch: expected char %0d last %b count %0d, got char %0d last %b count %0d",
                     want.ch, want.last, want.cnt, m_axis_tdata[CHAR_W-1:0], m_axis_tlast,
                     m_axis_tdata[CHAR_W +: COUNT_W]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned        n_digits;
    longint unsigned    lo;
    longint unsigned    hi;
    logic [VALUE_W-1:0] v;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_vecs[i]) begin
      offer(directed_vecs[i].value, directed_vecs[i].text);
      pause_sender();
    end

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i >= QUIET_FROM)
        quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: v = $urandom();
        2: begin
          // land next to a power of ten
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * DEC_BASE;
          v = VALUE_W'(lo - $urandom_range(0, 1));
        end
        default: begin
          // pick the digit count first so short values are common
          n_digits = $urandom_range(1, NUM_DIGITS);
          lo = 1;
          repeat (n_digits - 1) lo = lo * DEC_BASE;
          hi = (n_digits == NUM_DIGITS) ? 64'hFFFF_FFFF : lo * DEC_BASE - 1;
          if (n_digits == 1)
            lo = 0;
          v = VALUE_W'(lo + ($urandom() % (hi - lo + 1)));
        end
      endcase
      offer(v, "");
      pause_sender();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- unsigned_to_decimal_ascii.f -----
+incdir+hw/rtl
hw/rtl/u2da_pkg.sv
hw/rtl/u2da_dabble_stage.sv
hw/rtl/u2da_normalize.sv
hw/rtl/u2da_serializer.sv
hw/rtl/unsigned_to_decimal_ascii.sv
tb/sv/unsigned_to_decimal_ascii_test.sv
